// ===== hdl/pcps_pkg.sv =====
package pcps_pkg;

    typedef struct packed {
        logic [15:0]        target_x;
        logic [15:0]        target_y;
        logic [15:0]        target_z;
        logic [15:0]        source_x;
        logic [15:0]        source_y;
        logic [15:0]        source_z;
        logic signed [15:0] source_charge;
        logic               last_source;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] potential;
        logic               overflowed;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQRT,
        ST_DIV,
        ST_ACC
    } t_back_state;

    localparam logic REG_MIN_DIST_SQ = 1'b0;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = 3;

    localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

endpackage

// ===== hdl/pcps_front.sv =====
module pcps_front
    import pcps_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  t_in_item                  i_item,
    input  logic [2*COORD_BITS+1:0]   i_thresh,
    output logic                      o_wr,
    output logic [2*COORD_BITS+19:0]  o_wdata,
    output logic [1:0]                o_inflight
);

    localparam int CW = COORD_BITS;
    localparam int SW = 2 * COORD_BITS + 2;

    logic [CW-1:0]   r_dx, r_dy, r_dz;
    logic [15:0]     r_q1, r_q2;
    logic            r_last1, r_last2;
    logic            r_v1, r_v2;
    logic [2*CW-1:0] r_sx, r_sy, r_sz;
    logic [SW-1:0]   s_sum;
    logic            s_skip;

    function automatic logic [CW-1:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
        logic [CW-1:0] ca;
        logic [CW-1:0] cb;
        ca = CW'(a);
        cb = CW'(b);
        return (ca >= cb) ? (ca - cb) : (cb - ca);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
        end
        r_dx    <= abs_diff(i_item.target_x, i_item.source_x);
        r_dy    <= abs_diff(i_item.target_y, i_item.source_y);
        r_dz    <= abs_diff(i_item.target_z, i_item.source_z);
        r_q1    <= i_item.source_charge;
        r_last1 <= i_item.last_source;
        r_sx    <= r_dx * r_dx;
        r_sy    <= r_dy * r_dy;
        r_sz    <= r_dz * r_dz;
        r_q2    <= r_q1;
        r_last2 <= r_last1;
    end

    assign s_sum  = SW'(r_sx) + SW'(r_sy) + SW'(r_sz);
    assign s_skip = (s_sum <= i_thresh);

    assign o_wr       = r_v2;
    assign o_wdata    = {s_skip, r_last2, r_q2, s_sum};
    assign o_inflight = 2'(r_v1) + 2'(r_v2);

endmodule

// ===== hdl/pcps_fifo.sv =====
module pcps_fifo
    import pcps_pkg::*;
#(
    parameter int DATA_W = 52
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  logic [DATA_W-1:0]   i_wdata,
    input  logic                i_rd,
    output logic [DATA_W-1:0]   o_rdata,
    output logic                o_empty,
    output logic [QUEUE_AW:0]   o_count
);

    logic [DATA_W-1:0]   r_mem [QUEUE_DEPTH];
    logic [DATA_W-1:0]   r_rdata;
    logic [QUEUE_AW-1:0] r_wp, r_rp, n_rp;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW:0]   r_avail;
    logic                r_wr_d;

    assign n_rp = r_rp + QUEUE_AW'(i_rd);

    // The head is read through a register, so a written beat becomes visible
    // in the cycle after it lands in the memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
            r_avail <= '0;
            r_wr_d  <= 1'b0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            r_rp    <= n_rp;
            r_wr_d  <= i_wr;
            r_count <= r_count + (QUEUE_AW+1)'(i_wr) - (QUEUE_AW+1)'(i_rd);
            r_avail <= r_avail + (QUEUE_AW+1)'(r_wr_d) - (QUEUE_AW+1)'(i_rd);
        end
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
        r_rdata <= r_mem[n_rp];
    end

    assign o_rdata = r_rdata;
    assign o_empty = (r_avail == '0);
    assign o_count = r_count;

endmodule

// ===== hdl/pcps_back.sv =====
module pcps_back
    import pcps_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_empty,
    input  logic [2*COORD_BITS+19:0]  i_q_data,
    output logic                      o_q_rd,
    input  logic                      i_pop,
    output logic                      o_empty,
    output t_out_item                 o_result
);

    localparam int SW   = 2 * COORD_BITS + 2;
    localparam int RN   = COORD_BITS + 7;      // root bits
    localparam int NUMW = COORD_BITS + 30;     // dividend bits
    localparam int CNTW = $clog2(NUMW + 1);

    t_back_state r_state, n_state;

    logic [SW-1:0]   s_s;
    logic [15:0]     s_q;
    logic            s_last, s_skip;

    logic [2*RN-1:0] r_op;
    logic [RN+1:0]   r_rem;
    logic [RN-1:0]   r_root;
    logic [NUMW-1:0] r_num;
    logic [RN-1:0]   r_drem;
    logic [NUMW-1:0] r_quot;
    logic [CNTW-1:0] r_cnt;
    logic [15:0]     r_qmag;
    logic            r_neg, r_last, r_skip;
    logic signed [63:0] r_acc;
    logic            r_sat;
    logic            r_out_valid;
    t_out_item       r_out;

    logic [RN+1:0]   s_rem_t, s_trial;
    logic            s_sq_ge;
    logic [RN:0]     s_drem_t;
    logic            s_div_ge;
    logic signed [63:0] s_term, s_new_sum;
    logic [64:0]     s_sum65;
    logic            s_ovf;
    logic            s_out_free;
    logic            s_sqrt_done, s_div_done;
    logic            s_acc_go;

    assign {s_skip, s_last, s_q, s_s} = i_q_data;

    assign s_rem_t  = {r_rem[RN-1:0], r_op[2*RN-1 -: 2]};
    assign s_trial  = {r_root, 2'b01};
    assign s_sq_ge  = (s_rem_t >= s_trial);
    assign s_drem_t = {r_drem, r_num[NUMW-1]};
    assign s_div_ge = (s_drem_t >= {1'b0, r_root});

    assign s_sqrt_done = (r_cnt == CNTW'(RN - 1));
    assign s_div_done  = (r_cnt == CNTW'(NUMW - 1));

    // Skipped pairs add zero; otherwise the magnitude takes the charge's sign.
    always_comb begin
        if (r_skip) begin
            s_term = '0;
        end else if (r_neg) begin
            s_term = -$signed(64'(r_quot));
        end else begin
            s_term = $signed(64'(r_quot));
        end
    end

    assign s_sum65 = {r_acc[63], r_acc} + {s_term[63], s_term};
    assign s_ovf   = (s_sum65[64] != s_sum65[63]);
    assign s_new_sum = s_ovf ? (s_sum65[64] ? SUM_MIN : SUM_MAX) : $signed(s_sum65[63:0]);

    assign s_out_free = !r_out_valid || i_pop;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = s_skip ? ST_ACC : ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (s_sqrt_done) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (s_div_done) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                if (!r_last || s_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_rd   = 1'b0;
        s_acc_go = 1'b0;
        case (r_state)
            ST_IDLE: o_q_rd   = !i_q_empty;
            ST_ACC:  s_acc_go = !r_last || s_out_free;
            default: begin
                o_q_rd   = 1'b0;
                s_acc_go = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_acc_go) begin
                if (r_last) begin
                    r_acc <= '0;
                    r_sat <= 1'b0;
                end else begin
                    r_acc <= s_new_sum;
                    r_sat <= r_sat | s_ovf;
                end
            end
            if (s_acc_go && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end

        if (s_acc_go && r_last) begin
            r_out.potential  <= s_new_sum;
            r_out.overflowed <= r_sat | s_ovf;
        end

        case (r_state)
            ST_IDLE: begin
                r_op   <= {s_s, 12'b0};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_neg  <= s_q[15];
                r_qmag <= s_q[15] ? (16'd0 - s_q) : s_q;
                r_last <= s_last;
                r_skip <= s_skip;
            end
            ST_SQRT: begin
                r_op <= r_op << 2;
                if (s_sq_ge) begin
                    r_rem  <= s_rem_t - s_trial;
                    r_root <= {r_root[RN-2:0], 1'b1};
                end else begin
                    r_rem  <= s_rem_t;
                    r_root <= {r_root[RN-2:0], 1'b0};
                end
                if (s_sqrt_done) begin
                    r_cnt  <= '0;
                    r_num  <= {r_qmag, (NUMW-16)'(0)};
                    r_drem <= '0;
                    r_quot <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            ST_DIV: begin
                r_num <= r_num << 1;
                if (s_div_ge) begin
                    r_drem <= RN'(s_drem_t - {1'b0, r_root});
                    r_quot <= {r_quot[NUMW-2:0], 1'b1};
                end else begin
                    r_drem <= RN'(s_drem_t);
                    r_quot <= {r_quot[NUMW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

// ===== hdl/pairwise_coulomb_potential_sum_unit.sv =====
// Channel   Direction  Handshake               Beat
// input     in         push / full             i_item (t_in_item)
// result    out        pop / empty             o_result (t_out_item)
// config    in/out     psel penable pready     pwdata / prdata, 64 bits
//
// The front computes the squared distance in a pipeline of difference and square registers and queues
// each pair. The back takes one pair at a time: a COORD_BITS+7-bit square
// root, then a COORD_BITS+30-bit division, each one bit per cycle, after a pop
// and before an accumulate step; a skipped pair goes from the pop straight to the accumulate step.
// Reset is synchronous and clears the sum, the queue and the result valid flag.
// full rises when the queue plus the pipeline holds eight pairs; a waiting
// result stalls the back only on a pair marked last.
module pairwise_coulomb_potential_sum_unit
    import pcps_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_item,
    input  logic        pop,
    output logic        empty,
    output t_out_item   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int TW = 2 * COORD_BITS + 2;
    localparam int QW = 2 * COORD_BITS + 20;

    logic [TW-1:0]     r_thresh;
    logic              s_accept;
    logic              s_wr, s_rd, s_q_empty;
    logic [QW-1:0]     s_wdata, s_rdata;
    logic [1:0]        s_inflight;
    logic [QUEUE_AW:0] s_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= '0;
        end else if (psel && penable && pwrite && paddr[3] == REG_MIN_DIST_SQ) begin
            r_thresh <= pwdata[TW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_MIN_DIST_SQ) ? 64'(r_thresh) : 64'd0;

    assign full     = ((QUEUE_AW+2)'(s_count) + (QUEUE_AW+2)'(s_inflight))
                      >= (QUEUE_AW+2)'(QUEUE_DEPTH);
    assign s_accept = push && !full;

    pcps_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (s_accept),
        .i_item     (i_item),
        .i_thresh   (r_thresh),
        .o_wr       (s_wr),
        .o_wdata    (s_wdata),
        .o_inflight (s_inflight)
    );

    pcps_fifo #(.DATA_W(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (s_wr),
        .i_wdata (s_wdata),
        .i_rd    (s_rd),
        .o_rdata (s_rdata),
        .o_empty (s_q_empty),
        .o_count (s_count)
    );

    pcps_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (s_q_empty),
        .i_q_data  (s_rdata),
        .o_q_rd    (s_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

// ===== tb/sv/pairwise_coulomb_potential_sum_unit_tb.sv =====
`timescale 1ns / 1ps

import pcps_pkg::*;

class potential_scoreboard;
    t_out_item   sums_due[$];
    logic [33:0] skip_limit;
    logic signed [63:0] partial_sum;
    logic        clamped;
    int          mismatches;
    int          pairs_seen;
    int          pairs_skipped;
    int          sums_checked;

    function new();
        skip_limit    = '0;
        partial_sum   = '0;
        clamped       = 1'b0;
        mismatches    = 0;
        pairs_seen    = 0;
        pairs_skipped = 0;
        sums_checked  = 0;
    endfunction

    function void set_limit(logic [63:0] value);
        skip_limit = value[33:0];
    endfunction

    function int pending();
        return sums_due.size();
    endfunction

    // Digit-by-digit square root, floor of the real root.
    function logic [63:0] floor_root(logic [63:0] value);
        logic [63:0] root;
        logic [63:0] probe;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > value) probe = probe >> 2;
        while (probe != 0) begin
            if (value >= root + probe) begin
                value = value - (root + probe);
                root  = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function logic [63:0] axis_square(logic [15:0] a, logic [15:0] b);
        logic [63:0] diff;
        diff = (a >= b) ? 64'(a - b) : 64'(b - a);
        return diff * diff;
    endfunction

    function void note_pair(t_in_item pair);
        logic [63:0] dist_sq;
        logic [63:0] root6;
        logic [63:0] qmag;
        logic [63:0] mag;
        logic signed [64:0] wide;
        logic signed [63:0] term;
        t_out_item   due;
        pairs_seen++;
        dist_sq = axis_square(pair.target_x, pair.source_x)
                + axis_square(pair.target_y, pair.source_y)
                + axis_square(pair.target_z, pair.source_z);
        qmag = pair.source_charge[15] ? 64'(17'h10000 - {1'b0, pair.source_charge})
                                      : 64'(pair.source_charge);
        if (dist_sq > 64'(skip_limit)) begin
            root6 = floor_root(dist_sq << 12);
            if (root6 != 0) begin
                mag  = (qmag << 30) / root6;
                term = pair.source_charge[15] ? -$signed(mag) : $signed(mag);
                wide = 65'(partial_sum) + 65'(term);
                if (wide > 65'(SUM_MAX)) begin
                    partial_sum = SUM_MAX;
                    clamped     = 1'b1;
                end else if (wide < 65'(SUM_MIN)) begin
                    partial_sum = SUM_MIN;
                    clamped     = 1'b1;
                end else begin
                    partial_sum = wide[63:0];
                end
            end
        end else begin
            pairs_skipped++;
        end
        if (pair.last_source) begin
            due.potential  = partial_sum;
            due.overflowed = clamped;
            sums_due.push_back(due);
            partial_sum = '0;
            clamped     = 1'b0;
        end
    endfunction

    function void check_sum(t_out_item got);
        t_out_item due;
        if (sums_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with nothing due: potential %0d overflowed %0b",
                         $realtime, got.potential, got.overflowed);
            return;
        end
        due = sums_due.pop_front();
        sums_checked++;
        if (got.potential !== due.potential || got.overflowed !== due.overflowed) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: sum mismatch: expected %0d/%0b, got %0d/%0b", $realtime,
                         due.potential, due.overflowed, got.potential, got.overflowed);
        end
    endfunction
endclass

module pairwise_coulomb_potential_sum_unit_tb;
    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_item    i_item;
    logic        pop;
    logic        empty;
    t_out_item   o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    potential_scoreboard board;
    int burst_left;
    int phase_count;

    pairwise_coulomb_potential_sum_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .pop      (pop),
        .empty    (empty),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("TEST FAILED");
        $finish;
    end

    // Called at a falling edge; returns at a falling edge.
    task automatic write_limit(logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(REG_MIN_DIST_SQ) * 4'd8;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_limit(value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        phase_count++;
    endtask

    task automatic send_pair(t_in_item pair);
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
        end
        burst_left--;
        i_item <= pair;
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
        board.note_pair(pair);
        @(negedge i_clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        // Whole runs always end in a last beat, but leave room for the back end.
        repeat (150) @(negedge i_clk);
    endtask

    function automatic t_in_item make_pair(bit last, int spread);
        t_in_item p;
        p.target_x = 16'($urandom);
        p.target_y = 16'($urandom);
        p.target_z = 16'($urandom);
        if (spread == 0) begin
            p.source_x = 16'($urandom);
            p.source_y = 16'($urandom);
            p.source_z = 16'($urandom);
        end else begin
            p.source_x = p.target_x + 16'($urandom_range(0, spread));
            p.source_y = p.target_y - 16'($urandom_range(0, spread));
            p.source_z = p.target_z + 16'($urandom_range(0, spread));
        end
        p.source_charge = 16'($urandom);
        p.last_source   = last;
        return p;
    endfunction

    function automatic t_in_item fixed_pair(logic [15:0] t, logic [15:0] s,
                                            logic [15:0] q, bit last);
        t_in_item p;
        p.target_x = t; p.target_y = t; p.target_z = t;
        p.source_x = s; p.source_y = s; p.source_z = s;
        p.source_charge = q;
        p.last_source   = last;
        return p;
    endfunction

    // Receiver: pop probability changes from one random span to the next.
    initial begin
        int pop_pct;
        int span;
        pop     = 1'b0;
        pop_pct = 100;
        span    = 0;
        forever begin
            @(negedge i_clk);
            if (span == 0) begin
                case ($urandom_range(0, 3))
                    0: pop_pct = 100;
                    1: pop_pct = 70;
                    2: pop_pct = 30;
                    default: pop_pct = 5;
                endcase
                span = $urandom_range(50, 400);
            end
            span--;
            pop <= ($urandom_range(0, 99) < pop_pct);
            @(posedge i_clk);
            if (pop && !empty && i_rst_n) board.check_sum(o_result);
        end
    end

    initial begin
        logic [63:0] limits[6];
        int run_len;
        int spread;
        board       = new();
        burst_left  = 0;
        phase_count = 0;
        i_rst_n = 1'b0;
        push    = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, coincident points, zero charge, skipped last beat.
        write_limit(64'd0);
        send_pair(fixed_pair(16'h1234, 16'h1234, 16'd100, 1'b0));
        send_pair(fixed_pair(16'h0000, 16'hFFFF, 16'h7FFF, 1'b0));
        send_pair(fixed_pair(16'hFFFF, 16'h0000, 16'h8000, 1'b0));
        send_pair(fixed_pair(16'h0000, 16'hFFFF, 16'h0000, 1'b0));
        send_pair(fixed_pair(16'h0000, 16'h0001, 16'h8000, 1'b1));
        send_pair(fixed_pair(16'hFFFF, 16'hFFFE, 16'h7FFF, 1'b0));
        send_pair(fixed_pair(16'h5555, 16'h5555, 16'h7FFF, 1'b1));
        send_pair(fixed_pair(16'hFFFF, 16'hFFFF, 16'h0001, 1'b1));
        send_pair(fixed_pair(16'hAAAA, 16'h5555, 16'hFFFF, 1'b1));
        drain();
        // Squared distance exactly at the limit is skipped, a larger one is summed.
        write_limit(64'd3);
        send_pair(fixed_pair(16'h0100, 16'h0101, 16'h7FFF, 1'b1));
        send_pair(fixed_pair(16'h0100, 16'h0102, 16'h7FFF, 1'b0));
        send_pair(fixed_pair(16'h0101, 16'h0100, 16'h8000, 1'b1));
        drain();
        write_limit(64'hFFFF_FFFF_FFFF_FFFF);
        send_pair(fixed_pair(16'h0000, 16'hFFFF, 16'h7FFF, 1'b1));
        drain();

        limits[0] = 64'd0;
        limits[1] = 64'h3_FFFF_FFFF;
        limits[2] = 64'($urandom_range(0, 4096));
        limits[3] = 64'($urandom) << 2 | 64'($urandom_range(0, 3));
        limits[4] = 64'($urandom_range(1, 1 << 24));
        limits[5] = {$urandom, $urandom};
        for (int ph = 0; ph < 6; ph++) begin
            write_limit(limits[ph]);
            for (int n = 0; n < 215; n += run_len) begin
                run_len = $urandom_range(1, 10);
                for (int k = 0; k < run_len; k++) begin
                    case ($urandom_range(0, 3))
                        0: spread = 0;
                        1: spread = 3;
                        2: spread = 64;
                        default: spread = 4096;
                    endcase
                    send_pair(make_pair(k == run_len - 1, spread));
                end
                if (ph == 2 && n < 10) begin
                    push <= 1'b0;
                    while (board.pending() != 0) @(negedge i_clk);
                end
            end
            drain();
        end

        $display("Checked %0d sums from %0d pairs (%0d skipped) over %0d limit settings.",
                 board.sums_checked, board.pairs_seen, board.pairs_skipped, phase_count);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("Mismatches: %0d, sums still due: %0d", board.mismatches,
                     board.pending());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
